@@ design/mafs_pkg.sv @@
// Shared types and codes for the motor arming and failsafe controller.
package mafs_pkg;

    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 16;

    typedef enum logic [2:0] {
        MODE_DISARMED = 3'd0,
        MODE_ARMED    = 3'd1,
        MODE_FAILSAFE = 3'd2,
        MODE_CALIB    = 3'd3,
        MODE_DEPLOY   = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        BLOCK_READY    = 3'd0,
        BLOCK_NO_RC    = 3'd1,
        BLOCK_THROTTLE = 3'd2,
        BLOCK_CALIB    = 3'd3,
        BLOCK_SETTINGS = 3'd4
    } t_block;

    typedef enum logic [1:0] {
        SERVO_CENTER = 2'd0,
        SERVO_TRACK  = 2'd1,
        SERVO_DEPLOY = 2'd2
    } t_servo;

    localparam logic THROTTLE_FORCE_NEUTRAL = 1'b0;
    localparam logic THROTTLE_TRACK         = 1'b1;

    typedef struct packed {
        logic rc_ok;
        logic stick_neutral;
        logic calib_busy;
        logic settings_applying;
        logic arm_request;
        logic calib_request;
        logic calib_confirm;
        logic deploy_req;
        logic stow_req;
        logic disarm_request;
    } t_flags;

    typedef struct packed {
        t_mode  mode;
        logic   throttle_mode;
        t_servo servo_mode;
        t_block arm_block;
    } t_result;

endpackage

@@ design/mafs_next.sv @@
// Next-mode and drive-output logic for one flag sample.
module mafs_next import mafs_pkg::*; (
    input  t_mode   i_mode,
    input  t_flags  i_flags,
    output t_mode   o_next_mode,
    output t_result o_result
);

    t_block w_block;

    // first failing arm condition, evaluated every tick
    always_comb begin
        if (!i_flags.rc_ok) begin
            w_block = BLOCK_NO_RC;
        end else if (!i_flags.stick_neutral) begin
            w_block = BLOCK_THROTTLE;
        end else if (i_flags.calib_busy) begin
            w_block = BLOCK_CALIB;
        end else if (i_flags.settings_applying) begin
            w_block = BLOCK_SETTINGS;
        end else begin
            w_block = BLOCK_READY;
        end
    end

    always_comb begin
        case (i_mode)
            MODE_DISARMED: begin
                if (!i_flags.rc_ok) begin
                    o_next_mode = MODE_FAILSAFE;
                end else if (i_flags.stick_neutral && i_flags.calib_request &&
                             i_flags.calib_confirm && !i_flags.settings_applying) begin
                    o_next_mode = MODE_CALIB;
                end else if (i_flags.deploy_req) begin
                    o_next_mode = MODE_DEPLOY;
                end else if (i_flags.arm_request && (w_block == BLOCK_READY)) begin
                    o_next_mode = MODE_ARMED;
                end else begin
                    o_next_mode = MODE_DISARMED;
                end
            end
            MODE_ARMED: begin
                if (!i_flags.rc_ok) begin
                    o_next_mode = MODE_FAILSAFE;
                end else if (i_flags.disarm_request) begin
                    o_next_mode = MODE_DISARMED;
                end else begin
                    o_next_mode = MODE_ARMED;
                end
            end
            MODE_FAILSAFE: begin
                o_next_mode = i_flags.rc_ok ? MODE_DISARMED : MODE_FAILSAFE;
            end
            MODE_CALIB: begin
                o_next_mode = i_flags.rc_ok ? MODE_CALIB : MODE_FAILSAFE;
            end
            MODE_DEPLOY: begin
                if (!i_flags.rc_ok) begin
                    o_next_mode = MODE_FAILSAFE;
                end else if (i_flags.stow_req) begin
                    o_next_mode = MODE_DISARMED;
                end else begin
                    o_next_mode = MODE_DEPLOY;
                end
            end
            default: begin
                o_next_mode = MODE_FAILSAFE;
            end
        endcase
    end

    // throttle follows the new mode; servo deploys in deploy mode, else tracks while RC is ok, else centers
    always_comb begin
        o_result.mode          = o_next_mode;
        o_result.throttle_mode = (o_next_mode == MODE_ARMED) ? THROTTLE_TRACK
                                                             : THROTTLE_FORCE_NEUTRAL;
        if (o_next_mode == MODE_DEPLOY) begin
            o_result.servo_mode = SERVO_DEPLOY;
        end else if (i_flags.rc_ok) begin
            o_result.servo_mode = SERVO_TRACK;
        end else begin
            o_result.servo_mode = SERVO_CENTER;
        end
        o_result.arm_block = w_block;
    end

endmodule

@@ design/motor_arming_failsafe_fsm.sv @@
// Motor arming and failsafe mode controller, top level.
//
// One input word per control tick carries ten safety and request flags on
// the slave stream; each accepted word yields exactly one output word with
// the new mode, throttle mode, servo mode and arm-block reason.
// A word accepted on the slave stream passes the input register, then the
// result register. Throughput: one word per cycle while the receiver takes
// words; the mode register updates as a word enters the result register.
// The input register and result register form a two-deep pipeline, so a new
// word is taken while a finished result waits; when the receiver stalls both
// fill and o_s_axis_tready drops until the result is taken.
// Synchronous active-low reset empties both stages and sets the mode to
// disarmed. Mode codes: 0 disarmed, 1 armed, 2 failsafe, 3 calibration,
// 4 deploy.
module motor_arming_failsafe_fsm import mafs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // rc_ok, stick_neutral, calib_busy, settings_applying, arm_request,
    // calib_request, calib_confirm, deploy_req, stow_req,
    // disarm_request (bits 0..9), zeros above
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // mode[2:0], throttle_mode[3], servo_mode[5:4], arm_block[8:6], zeros above
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic    r_in_valid;
    t_flags  r_in_flags;
    logic    r_out_valid;
    t_result r_out_res;
    t_mode   r_mode;

    t_flags  w_flags;
    t_mode   n_mode;
    t_result w_res;
    logic    w_advance;
    logic    w_in_accept;

    always_comb begin
        w_flags.rc_ok             = i_s_axis_tdata[0];
        w_flags.stick_neutral     = i_s_axis_tdata[1];
        w_flags.calib_busy        = i_s_axis_tdata[2];
        w_flags.settings_applying = i_s_axis_tdata[3];
        w_flags.arm_request       = i_s_axis_tdata[4];
        w_flags.calib_request     = i_s_axis_tdata[5];
        w_flags.calib_confirm     = i_s_axis_tdata[6];
        w_flags.deploy_req        = i_s_axis_tdata[7];
        w_flags.stow_req          = i_s_axis_tdata[8];
        w_flags.disarm_request    = i_s_axis_tdata[9];
    end

    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;

    mafs_next u_next (
        .i_mode      (r_mode),
        .i_flags     (r_in_flags),
        .o_next_mode (n_mode),
        .o_result    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_DISARMED;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_flags <= w_flags;
        end
        if (w_advance) begin
            r_out_res <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-9){1'b0}}, r_out_res.arm_block,
                              r_out_res.servo_mode, r_out_res.throttle_mode,
                              r_out_res.mode};

endmodule

@@ design/mafs_chk.sv @@
// Port-level checks for the motor arming and failsafe controller.
module mafs_chk import mafs_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output word changed while stalled");

    // throttle tracks the stick only in armed
    a_throttle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[3] == THROTTLE_TRACK) == (o_m_axis_tdata[2:0] == MODE_ARMED))
        else $error("throttle mode disagrees with mode");

    // servo holds deploy exactly in deploy mode
    a_servo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[5:4] == SERVO_DEPLOY) == (o_m_axis_tdata[2:0] == MODE_DEPLOY))
        else $error("servo mode disagrees with mode");

    // RC loss always lands in failsafe and centers the servo
    a_rc_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[8:6] == BLOCK_NO_RC) |->
            (o_m_axis_tdata[2:0] == MODE_FAILSAFE) && (o_m_axis_tdata[5:4] == SERVO_CENTER))
        else $error("RC loss did not force failsafe");

    // an idle output only turns valid after an accepted word has passed the input register
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(i_s_axis_tvalid && o_s_axis_tready, 2))
        else $error("output word with nothing accepted");

endmodule

bind motor_arming_failsafe_fsm mafs_chk u_mafs_chk (.*);
